>>> src/aimd_congestion_window_assert.svh
// Assertion macros shared by the checker files of this block.
// Each macro expects signals named clock and reset in the calling scope.
`ifndef AIMD_CONGESTION_WINDOW_ASSERT_SVH
`define AIMD_CONGESTION_WINDOW_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define AIMD_CW_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("aimd_congestion_window: check failed");

// Next-cycle implication, disabled while reset is high.
`define AIMD_CW_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("aimd_congestion_window: check failed");

`endif

>>> src/aimd_cw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package aimd_cw_pkg;

   localparam int FRAC_BITS_DEFAULT = 8;

   // Byte address width of the register port: five 32-bit registers.
   localparam int CSR_ADDR_W = 5;

   // Mode register codes; the unused code behaves as MODE_DELAY.
   localparam logic [1:0] MODE_THRESH = 2'd0;
   localparam logic [1:0] MODE_COUNT  = 2'd1;
   localparam logic [1:0] MODE_DELAY  = 2'd2;

   typedef enum logic {
      MD_MUL,
      MD_DIV
   } md_op_type;

   typedef struct packed {
      logic      start;
      md_op_type op;
   } md_req_type;

   typedef struct packed {
      logic busy;
      logic done;
   } md_stat_type;

   function automatic int max_int(input int a, input int b);
      return (a > b) ? a : b;
   endfunction

   // Widths of the step and factor registers: wide enough for their reset values.
   function automatic int step_width(input int frac_bits);
      return max_int(12, frac_bits + 2);
   endfunction

   function automatic int decr_width(input int frac_bits);
      return max_int(12, frac_bits);
   endfunction

endpackage

`default_nettype wire

>>> src/aimd_cw_csr.sv
`timescale 1ns / 1ps
`default_nettype none

module aimd_cw_csr #(
   parameter int FRAC_BITS = aimd_cw_pkg::FRAC_BITS_DEFAULT
) (
   input  wire logic                                         clock,
   input  wire logic                                         reset,
   input  wire logic                                         csr_psel,
   input  wire logic                                         csr_penable,
   input  wire logic                                         csr_pwrite,
   input  wire logic [aimd_cw_pkg::CSR_ADDR_W-1:0]           csr_paddr,
   input  wire logic [31:0]                                  csr_pwdata,
   output logic      [31:0]                                  csr_prdata,
   output logic      [1:0]                                   mode,
   output logic      [15:0]                                  rtt_limit_ms,
   output logic      [23:0]                                  slow_start_limit,
   output logic      [aimd_cw_pkg::step_width(FRAC_BITS)-1:0] increase_step,
   output logic      [aimd_cw_pkg::decr_width(FRAC_BITS)-1:0] decrease_factor
);

   localparam int STEP_W = aimd_cw_pkg::step_width(FRAC_BITS);
   localparam int DECR_W = aimd_cw_pkg::decr_width(FRAC_BITS);

   localparam logic [2:0] IDX_MODE = 3'd0;
   localparam logic [2:0] IDX_RTT  = 3'd1;
   localparam logic [2:0] IDX_SSL  = 3'd2;
   localparam logic [2:0] IDX_STEP = 3'd3;
   localparam logic [2:0] IDX_DECR = 3'd4;

   localparam logic [23:0]       SSL_RESET  = 24'(60 * (1 << FRAC_BITS));
   localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'((5 * (1 << FRAC_BITS)) / 2);
   localparam logic [DECR_W-1:0] DECR_RESET = DECR_W'((1 << FRAC_BITS) / 2);

   logic [1:0]        mode_ff;
   logic [15:0]       rtt_ff;
   logic [23:0]       ssl_ff;
   logic [STEP_W-1:0] step_ff;
   logic [DECR_W-1:0] decr_ff;
   logic [2:0]        index;
   logic              wr_en;

   assign index = csr_paddr[aimd_cw_pkg::CSR_ADDR_W-1:2];
   assign wr_en = csr_psel & csr_penable & csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= aimd_cw_pkg::MODE_DELAY;
         rtt_ff  <= 16'd80;
         ssl_ff  <= SSL_RESET;
         step_ff <= STEP_RESET;
         decr_ff <= DECR_RESET;
      end else if (wr_en) begin
         case (index)
            IDX_MODE: mode_ff <= csr_pwdata[1:0];
            IDX_RTT:  rtt_ff  <= csr_pwdata[15:0];
            IDX_SSL:  ssl_ff  <= csr_pwdata[23:0];
            IDX_STEP: step_ff <= STEP_W'(csr_pwdata[11:0]);
            IDX_DECR: decr_ff <= DECR_W'(csr_pwdata[11:0]);
            default: ;
         endcase
      end
   end

   always_comb begin
      case (index)
         IDX_MODE: csr_prdata = 32'(mode_ff);
         IDX_RTT:  csr_prdata = 32'(rtt_ff);
         IDX_SSL:  csr_prdata = 32'(ssl_ff);
         IDX_STEP: csr_prdata = 32'(step_ff);
         IDX_DECR: csr_prdata = 32'(decr_ff);
         default:  csr_prdata = '0;
      endcase
   end

   assign mode             = mode_ff;
   assign rtt_limit_ms     = rtt_ff;
   assign slow_start_limit = ssl_ff;
   assign increase_step    = step_ff;
   assign decrease_factor  = decr_ff;

endmodule

`default_nettype wire

>>> src/aimd_cw_muldiv.sv
`timescale 1ns / 1ps
`default_nettype none

// Shared shift-add multiplier and restoring divider, one bit per cycle.
// Multiply: opa * opb. Divide: (opb << FRAC_BITS) / opa, opa nonzero.
module aimd_cw_muldiv #(
   parameter int FRAC_BITS = aimd_cw_pkg::FRAC_BITS_DEFAULT
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire aimd_cw_pkg::md_req_type  ctl,
   input  wire logic [16+FRAC_BITS-1:0]  opa,
   input  wire logic [aimd_cw_pkg::max_int(aimd_cw_pkg::step_width(FRAC_BITS),
                      aimd_cw_pkg::decr_width(FRAC_BITS))-1:0] opb,
   output aimd_cw_pkg::md_stat_type      stat,
   output logic [16+FRAC_BITS+aimd_cw_pkg::max_int(aimd_cw_pkg::step_width(FRAC_BITS),
                 aimd_cw_pkg::decr_width(FRAC_BITS))-1:0] result
);

   localparam int WIN_BITS = 16 + FRAC_BITS;
   localparam int OPB_W    = aimd_cw_pkg::max_int(aimd_cw_pkg::step_width(FRAC_BITS),
                                                 aimd_cw_pkg::decr_width(FRAC_BITS));
   localparam int PROD_W   = WIN_BITS + OPB_W;
   localparam int SH_W     = OPB_W + FRAC_BITS;
   localparam int ADD_W    = PROD_W + 1;
   localparam int CNT_W    = $clog2(SH_W + 1);

   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   aimd_cw_pkg::md_op_type op_ff, op_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic [PROD_W-1:0]      acc_ff, acc_in;
   logic [SH_W-1:0]        sh_ff, sh_in;
   logic [WIN_BITS-1:0]    opa_ff, opa_in;

   logic                   is_div;
   logic [WIN_BITS:0]      div_shift;
   logic [ADD_W-1:0]       a_ext, add_x, add_y, add_sum;
   logic                   neg;

   assign is_div    = (op_ff == aimd_cw_pkg::MD_DIV);
   assign div_shift = {acc_ff[WIN_BITS-1:0], sh_ff[SH_W-1]};
   assign a_ext     = ADD_W'(opa_ff);
   assign add_x     = is_div ? ADD_W'(div_shift) : {1'b0, acc_ff[PROD_W-2:0], 1'b0};
   assign add_y     = is_div ? ~a_ext : (sh_ff[SH_W-1] ? a_ext : '0);
   // The one adder: accumulate for multiply, trial subtract for divide.
   assign add_sum   = add_x + add_y + ADD_W'(is_div);
   assign neg       = add_sum[ADD_W-1];

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      op_in   = op_ff;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      sh_in   = sh_ff;
      opa_in  = opa_ff;
      if (busy_ff) begin
         if (is_div) begin
            acc_in = neg ? PROD_W'(div_shift) : PROD_W'(add_sum[WIN_BITS:0]);
            sh_in  = {sh_ff[SH_W-2:0], ~neg};
         end else begin
            acc_in = add_sum[PROD_W-1:0];
            sh_in  = {sh_ff[SH_W-2:0], 1'b0};
         end
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end else if (ctl.start) begin
         busy_in = 1'b1;
         op_in   = ctl.op;
         cnt_in  = (ctl.op == aimd_cw_pkg::MD_DIV) ? CNT_W'(SH_W - 1) : CNT_W'(OPB_W - 1);
         acc_in  = '0;
         sh_in   = {opb, {FRAC_BITS{1'b0}}};
         opa_in  = opa;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      op_ff  <= op_in;
      cnt_ff <= cnt_in;
      acc_ff <= acc_in;
      sh_ff  <= sh_in;
      opa_ff <= opa_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign result    = is_div ? PROD_W'(sh_ff) : acc_ff;

endmodule

`default_nettype wire

>>> src/aimd_congestion_window.sv
// AIMD congestion window controller.
// Input channel (req_): one word per packet event. req_func 0 is a datagram
// sent (req_by_timeout halves the window above 2.0), req_func 1 is an ack
// whose round-trip time is req_ack_time_ms - req_sent_time_ms modulo 2^32.
// Result channel (rsp_): one word per event, rsp_window, the integer part of
// the updated Q16.FRAC_BITS window. Registers sit on the csr_ APB port.
// An event without arithmetic passes from acceptance through ST_EVAL and
// ST_DONE to the output register; a mode-0 multiply or an alpha/window
// divide passes through ST_CALC between them. The shared shift-add/restoring
// unit works one bit per cycle; with the default FRAC_BITS 8 it handles 12
// multiplier bits and 20 quotient bits. req_stall is high while an event is
// in work.
// A finished word waits in the output register while rsp_stall is high; the
// next event is accepted meanwhile and holds in its last step until the
// output register frees. Reset loads the default registers, a window of
// 13.0 and zero overrun counters, and drops any pending result.
`timescale 1ns / 1ps
`default_nettype none

module aimd_congestion_window #(
   parameter int FRAC_BITS = aimd_cw_pkg::FRAC_BITS_DEFAULT
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic                                 req_func,
   input  wire logic                                 req_by_timeout,
   input  wire logic [31:0]                          req_sent_time_ms,
   input  wire logic [31:0]                          req_ack_time_ms,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic      [15:0]                          rsp_window,
   input  wire logic                                 csr_psel,
   input  wire logic                                 csr_penable,
   input  wire logic                                 csr_pwrite,
   input  wire logic [aimd_cw_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  wire logic [31:0]                          csr_pwdata,
   output logic      [31:0]                          csr_prdata,
   output logic                                      csr_pready
);

   localparam int WIN_BITS = 16 + FRAC_BITS;
   localparam int STEP_W   = aimd_cw_pkg::step_width(FRAC_BITS);
   localparam int DECR_W   = aimd_cw_pkg::decr_width(FRAC_BITS);
   localparam int OPB_W    = aimd_cw_pkg::max_int(STEP_W, DECR_W);
   localparam int PROD_W   = WIN_BITS + OPB_W;
   localparam int CMP_W    = aimd_cw_pkg::max_int(WIN_BITS, 24);

   localparam logic [WIN_BITS-1:0] ONE_Q     = WIN_BITS'(1) << FRAC_BITS;
   localparam logic [WIN_BITS-1:0] TWO_Q     = WIN_BITS'(2) << FRAC_BITS;
   localparam logic [WIN_BITS-1:0] WIN_MAX   = '1;
   localparam logic [WIN_BITS-1:0] WIN_RESET = WIN_BITS'(13) << FRAC_BITS;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EVAL,
      ST_CALC,
      ST_DONE
   } state_type;

   typedef enum logic [2:0] {
      ACT_KEEP,
      ACT_HALF,
      ACT_ADD_STEP,
      ACT_MUL,
      ACT_SUB,
      ACT_CUT,
      ACT_COUNT,
      ACT_RECIP
   } action_type;

   logic [1:0]        mode;
   logic [15:0]       rtt_limit_ms;
   logic [23:0]       slow_start_limit;
   logic [STEP_W-1:0] increase_step;
   logic [DECR_W-1:0] decrease_factor;

   aimd_cw_pkg::md_req_type  md_req;
   aimd_cw_pkg::md_stat_type md_stat;
   logic [PROD_W-1:0]        md_result;
   logic [OPB_W-1:0]         md_opb;

   state_type           state_ff, state_in;
   action_type          action_ff, action_in;
   logic                func_ff, func_in;
   logic                timeout_ff, timeout_in;
   logic [31:0]         rtt_ff, rtt_in;
   logic [WIN_BITS-1:0] window_ff, window_in;
   logic [15:0]         ovr_count_ff, ovr_count_in;
   logic [15:0]         ovr_limit_ff, ovr_limit_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [15:0]         rsp_window_ff, rsp_window_in;

   logic                over;
   logic                at_limit;
   logic                out_free;
   logic [WIN_BITS:0]   sum_step;
   logic [WIN_BITS:0]   sum_recip;
   logic [WIN_BITS-1:0] beta_w;
   logic [WIN_BITS-1:0] w_calc;
   logic [WIN_BITS-1:0] w_next;

   aimd_cw_csr #(
      .FRAC_BITS(FRAC_BITS)
   ) u_csr (
      .clock           (clock),
      .reset           (reset),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .mode            (mode),
      .rtt_limit_ms    (rtt_limit_ms),
      .slow_start_limit(slow_start_limit),
      .increase_step   (increase_step),
      .decrease_factor (decrease_factor)
   );

   aimd_cw_muldiv #(
      .FRAC_BITS(FRAC_BITS)
   ) u_muldiv (
      .clock (clock),
      .reset (reset),
      .ctl   (md_req),
      .opa   (window_ff),
      .opb   (md_opb),
      .stat  (md_stat),
      .result(md_result)
   );

   assign csr_pready = 1'b1;

   assign over     = rtt_ff > 32'(rtt_limit_ms);
   assign at_limit = CMP_W'(window_ff) >= CMP_W'(slow_start_limit);
   assign out_free = ~rsp_valid_ff | ~rsp_stall;
   assign md_opb   = (action_in == ACT_MUL) ? OPB_W'(decrease_factor) : OPB_W'(increase_step);

   assign sum_step  = {1'b0, window_ff} + (WIN_BITS + 1)'(increase_step);
   assign sum_recip = {1'b0, window_ff} + {1'b0, md_result[WIN_BITS-1:0]};
   assign beta_w    = WIN_BITS'(decrease_factor);

   // New window before the lower clamp; increases saturate at the top.
   always_comb begin
      case (action_ff)
         ACT_HALF:     w_calc = window_ff >> 1;
         ACT_ADD_STEP: w_calc = sum_step[WIN_BITS] ? WIN_MAX : sum_step[WIN_BITS-1:0];
         ACT_MUL: begin
            if (md_result[PROD_W-1:WIN_BITS+FRAC_BITS] != '0) begin
               w_calc = WIN_MAX;
            end else begin
               w_calc = md_result[WIN_BITS+FRAC_BITS-1:FRAC_BITS];
            end
         end
         ACT_SUB, ACT_CUT: w_calc = (window_ff > beta_w) ? window_ff - beta_w : '0;
         ACT_RECIP:    w_calc = sum_recip[WIN_BITS] ? WIN_MAX : sum_recip[WIN_BITS-1:0];
         default:      w_calc = window_ff;
      endcase
   end

   assign w_next = (w_calc < ONE_Q) ? ONE_Q : w_calc;

   always_comb begin
      state_in      = state_ff;
      action_in     = action_ff;
      func_in       = func_ff;
      timeout_in    = timeout_ff;
      rtt_in        = rtt_ff;
      window_in     = window_ff;
      ovr_count_in  = ovr_count_ff;
      ovr_limit_in  = ovr_limit_ff;
      rsp_valid_in  = rsp_valid_ff & rsp_stall;
      rsp_window_in = rsp_window_ff;
      md_req.start  = 1'b0;
      md_req.op     = aimd_cw_pkg::MD_MUL;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               func_in    = req_func;
               timeout_in = req_by_timeout;
               rtt_in     = req_ack_time_ms - req_sent_time_ms;
               state_in   = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (!func_ff) begin
               action_in = (timeout_ff && window_ff > TWO_Q) ? ACT_HALF : ACT_KEEP;
            end else begin
               case (mode)
                  aimd_cw_pkg::MODE_THRESH: action_in = at_limit ? ACT_MUL : ACT_ADD_STEP;
                  aimd_cw_pkg::MODE_COUNT: begin
                     if (!over) begin
                        action_in = ACT_RECIP;
                     end else if (ovr_count_ff >= ovr_limit_ff) begin
                        action_in = ACT_CUT;
                     end else begin
                        action_in = ACT_COUNT;
                     end
                  end
                  default: action_in = over ? ACT_SUB : ACT_RECIP;
               endcase
            end
            // Multiply and divide go to the shared unit; the rest finish directly.
            if ((action_in == ACT_MUL || action_in == ACT_RECIP) && !md_stat.busy) begin
               md_req.start = 1'b1;
               md_req.op    = (action_in == ACT_RECIP) ? aimd_cw_pkg::MD_DIV
                                                       : aimd_cw_pkg::MD_MUL;
               state_in     = ST_CALC;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_CALC: begin
            if (md_stat.done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // Hold until the output register is free.
            if (out_free) begin
               window_in     = w_next;
               rsp_valid_in  = 1'b1;
               rsp_window_in = w_next[WIN_BITS-1:FRAC_BITS];
               if (action_ff == ACT_CUT) begin
                  ovr_count_in = '0;
                  ovr_limit_in = window_ff[WIN_BITS-1:FRAC_BITS];
               end else if (action_ff == ACT_COUNT) begin
                  ovr_count_in = ovr_count_ff + 16'd1;
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         window_ff    <= WIN_RESET;
         ovr_count_ff <= '0;
         ovr_limit_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         window_ff    <= window_in;
         ovr_count_ff <= ovr_count_in;
         ovr_limit_ff <= ovr_limit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      action_ff     <= action_in;
      func_ff       <= func_in;
      timeout_ff    <= timeout_in;
      rtt_ff        <= rtt_in;
      rsp_window_ff <= rsp_window_in;
   end

   assign req_stall  = reset | (state_ff != ST_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_window = rsp_window_ff;

endmodule

`default_nettype wire

>>> src/aimd_cw_checker.sv
`timescale 1ns / 1ps
`default_nettype none

`include "aimd_congestion_window_assert.svh"

module aimd_cw_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [15:0] rsp_window
);

   // One event at a time: the input side closes right after a word is taken.
   `AIMD_CW_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall)

   // The window never drops below 1.0.
   `AIMD_CW_ASSERT_NOW(a_window_nonzero, rsp_valid, rsp_window != 16'd0)

   // A new result only comes out of an event in work.
   `AIMD_CW_ASSERT_NOW(a_result_from_work, $rose(rsp_valid), $past(req_stall))

   // A stalled result holds.
   `AIMD_CW_ASSERT_NEXT(a_result_holds, rsp_valid && rsp_stall,
                        rsp_valid && $stable(rsp_window))

endmodule

bind aimd_congestion_window aimd_cw_checker u_checker (.*);

`default_nettype wire

>>> bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

   localparam int FRAC = aimd_cw_pkg::FRAC_BITS_DEFAULT;
   localparam int WIN_W = 16 + FRAC;

   // register indexes on the csr port
   localparam int REG_MODE       = 0;
   localparam int REG_RTT_LIMIT  = 1;
   localparam int REG_SS_LIMIT   = 2;
   localparam int REG_INC_STEP   = 3;
   localparam int REG_DEC_FACTOR = 4;
   localparam int REG_UNMAPPED   = 5;

   localparam logic [1:0] MODE_SPARE = 2'd3;
   localparam logic FUNC_SENT = 1'b0;
   localparam logic FUNC_ACK  = 1'b1;

   localparam logic [35:0] ONE_Q   = 36'd1 << FRAC;
   localparam logic [35:0] WIN_MAX = (36'd1 << WIN_W) - 36'd1;

   localparam int PHASES         = 12;
   localparam int WORDS_PER_PHASE = 152;
   localparam int LONG_HOLD      = 300;
   localparam int DRAIN_CYCLES   = 30;
   localparam int QUIET_LIMIT    = 4000;

   typedef struct packed {
      logic        func;
      logic        by_timeout;
      logic [31:0] sent_time;
      logic [31:0] ack_time;
   } req_word_t;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_func = 1'b0;
   logic        req_by_timeout = 1'b0;
   logic [31:0] req_sent_time_ms = '0;
   logic [31:0] req_ack_time_ms = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [15:0] rsp_window;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [aimd_cw_pkg::CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   aimd_congestion_window dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_func          (req_func),
      .req_by_timeout    (req_by_timeout),
      .req_sent_time_ms  (req_sent_time_ms),
      .req_ack_time_ms   (req_ack_time_ms),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_window        (rsp_window),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // shadow registers and window state, reset values
   logic [1:0]       cfg_mode = aimd_cw_pkg::MODE_DELAY;
   logic [15:0]      cfg_rtt_limit = 16'd80;
   logic [23:0]      cfg_ss_limit = 24'(60 * ONE_Q);
   logic [11:0]      cfg_inc = 12'((5 * ONE_Q) / 2);
   logic [11:0]      cfg_dec = 12'(ONE_Q / 2);
   logic [WIN_W-1:0] win_q = WIN_W'(13 * ONE_Q);
   logic [15:0]      overrun_count = '0;
   logic [15:0]      overrun_limit = '0;

   req_word_t   pending_words[$];
   logic [15:0] window_expect[$];
   logic [15:0] window_want;
   int          err_count = 0;

   function automatic logic [35:0] shrink_by_beta(input logic [35:0] w);
      return (w > {24'd0, cfg_dec}) ? w - {24'd0, cfg_dec} : '0;
   endfunction

   function automatic logic [35:0] grow_by_recip(input logic [35:0] w);
      logic [35:0] num;
      num = {24'd0, cfg_inc} << FRAC;
      return (w == '0) ? w : w + num / w;
   endfunction

   // advance the window by one event and return the integer window
   function automatic logic [15:0] advance_window(input req_word_t wd);
      logic [35:0] w;
      logic [47:0] prod;
      logic [31:0] rtt;
      logic        over;
      w = {12'd0, win_q};
      if (wd.func == FUNC_SENT) begin
         if (wd.by_timeout && w > (ONE_Q << 1)) w = w >> 1;
      end else begin
         rtt = wd.ack_time - wd.sent_time;
         over = rtt > {16'd0, cfg_rtt_limit};
         case (cfg_mode)
            aimd_cw_pkg::MODE_THRESH: begin
               if (w >= {12'd0, cfg_ss_limit}) begin
                  prod = w * cfg_dec;
                  w = 36'(prod >> FRAC);
               end else begin
                  w = w + {24'd0, cfg_inc};
               end
            end
            aimd_cw_pkg::MODE_COUNT: begin
               if (over) begin
                  if (overrun_count >= overrun_limit) begin
                     overrun_count = '0;
                     overrun_limit = w[FRAC+15:FRAC];
                     w = shrink_by_beta(w);
                  end else if (overrun_count != 16'hFFFF) begin
                     overrun_count = overrun_count + 16'd1;
                  end
               end else begin
                  w = grow_by_recip(w);
               end
            end
            default: begin
               if (over) w = shrink_by_beta(w);
               else w = grow_by_recip(w);
            end
         endcase
      end
      if (w > WIN_MAX) w = WIN_MAX;
      if (w < ONE_Q) w = ONE_Q;
      win_q = w[WIN_W-1:0];
      return win_q[FRAC+15:FRAC];
   endfunction

   // sender: bursts of words with random gaps
   int burst_left = 1;
   int gap_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            window_expect.push_back(advance_window('{req_func, req_by_timeout,
                                                     req_sent_time_ms, req_ack_time_ms}));
         end
         // hold a stalled word, otherwise offer the next one
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left <= gap_left - 1;
               req_valid <= 1'b0;
            end else if (pending_words.size() > 0) begin
               req_word_t nxt;
               nxt = pending_words.pop_front();
               req_func <= nxt.func;
               req_by_timeout <= nxt.by_timeout;
               req_sent_time_ms <= nxt.sent_time;
               req_ack_time_ms <= nxt.ack_time;
               req_valid <= 1'b1;
               if (burst_left <= 1) begin
                  burst_left <= $urandom_range(1, 24);
                  gap_left <= ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 40);
               end else begin
                  burst_left <= burst_left - 1;
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver: stall pattern that changes now and then, plus long holds on request
   int hold_ticket = 0;
   int hold_served = 0;
   int hold_left = 0;
   int pattern_left = 0;
   int stall_pct = 0;
   int pct_choices[4] = '{0, 25, 50, 90};

   always @(posedge clock) begin
      if (hold_served != hold_ticket) begin
         hold_served <= hold_ticket;
         hold_left <= LONG_HOLD;
         rsp_stall <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         if (pattern_left == 0) begin
            pattern_left <= $urandom_range(16, 96);
            stall_pct <= pct_choices[$urandom_range(0, 3)];
         end else begin
            pattern_left <= pattern_left - 1;
         end
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (window_expect.size() == 0) begin
            $display("%0t unexpected window word: expected none, actual %0d",
                     $time, rsp_window);
            err_count++;
         end else begin
            window_want = window_expect.pop_front();
            if (rsp_window !== window_want) begin
               $display("%0t window mismatch: expected %0d, actual %0d",
                        $time, window_want, rsp_window);
               err_count++;
            end
         end
      end
   end

   int quiet_cycles = 0;

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_psel)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   task automatic csr_xfer(input logic wr, input int idx, input logic [31:0] wdata,
                           output logic [31:0] rdata);
      logic [aimd_cw_pkg::CSR_ADDR_W-1:0] addr;
      addr = aimd_cw_pkg::CSR_ADDR_W'(idx * 4);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= wr;
      csr_paddr <= addr;
      csr_pwdata <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      rdata = csr_prdata;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // write a register, mirror it, and read it back if it is mapped
   task automatic set_reg(input int idx, input logic [31:0] val);
      logic [31:0] rd;
      logic [31:0] want;
      logic        mapped;
      mapped = 1'b1;
      want = '0;
      csr_xfer(1'b1, idx, val, rd);
      case (idx)
         REG_MODE: begin
            cfg_mode = val[1:0];
            want = {30'd0, cfg_mode};
         end
         REG_RTT_LIMIT: begin
            cfg_rtt_limit = val[15:0];
            want = {16'd0, cfg_rtt_limit};
         end
         REG_SS_LIMIT: begin
            cfg_ss_limit = val[23:0];
            want = {8'd0, cfg_ss_limit};
         end
         REG_INC_STEP: begin
            cfg_inc = val[11:0];
            want = {20'd0, cfg_inc};
         end
         REG_DEC_FACTOR: begin
            cfg_dec = val[11:0];
            want = {20'd0, cfg_dec};
         end
         default: mapped = 1'b0;
      endcase
      if (mapped) begin
         csr_xfer(1'b0, idx, '0, rd);
         if (rd !== want) begin
            $display("%0t register %0d readback: expected %0h, actual %0h",
                     $time, idx, want, rd);
            err_count++;
         end
      end
   endtask

   task automatic push_sent(input logic tmo);
      pending_words.push_back('{FUNC_SENT, tmo, $urandom(), $urandom()});
   endtask

   task automatic push_ack(input logic [31:0] sent, input logic [31:0] ack);
      pending_words.push_back('{FUNC_ACK, 1'($urandom_range(0, 1)), sent, ack});
   endtask

   task automatic push_random_word();
      logic [31:0] sent;
      logic [31:0] rtt;
      int          k;
      k = $urandom_range(0, 99);
      sent = $urandom();
      if (k < 25) begin
         push_sent(1'($urandom_range(0, 1)));
      end else begin
         // bias round-trip times toward the limit so both branches get hit
         if (k < 65) rtt = {16'd0, cfg_rtt_limit} + $urandom_range(0, 6) - 3;
         else if (k < 80) rtt = $urandom_range(0, cfg_rtt_limit);
         else if (k < 90) rtt = {16'd0, cfg_rtt_limit} + $urandom_range(1, 5000);
         else rtt = $urandom();
         push_ack(sent, sent + rtt);
      end
   endtask

   task automatic wait_drained();
      while (pending_words.size() != 0 || req_valid || window_expect.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_value(input logic [31:0] top, input logic [31:0] lo,
                                              input logic [31:0] hi);
      case ($urandom_range(0, 5))
         0: return '0;
         1: return top;
         2: return $urandom_range(0, top);
         default: return $urandom_range(lo, hi);
      endcase
   endfunction

   logic [1:0] mode_seq[4] = '{aimd_cw_pkg::MODE_THRESH, aimd_cw_pkg::MODE_COUNT,
                               aimd_cw_pkg::MODE_DELAY, MODE_SPARE};

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // default registers: halving, limit edge, wrapped and negative round trips
      push_sent(1'b0);
      push_sent(1'b1);
      push_ack(32'd1000, 32'd1080);
      push_ack(32'd1000, 32'd1081);
      push_ack(32'hFFFF_FFFF, 32'd0);
      push_ack(32'd0, 32'hFFFF_FFFF);
      push_ack(32'd100, 32'd50);
      repeat (4) push_sent(1'b1);
      wait_drained();

      // multiply up to saturation; unmapped address must be ignored
      set_reg(REG_UNMAPPED, 32'hFFFF_FFFF);
      set_reg(REG_MODE, {30'd0, aimd_cw_pkg::MODE_THRESH});
      set_reg(REG_SS_LIMIT, 32'd0);
      set_reg(REG_DEC_FACTOR, 32'hFFF);
      set_reg(REG_INC_STEP, 32'hFFF);
      set_reg(REG_RTT_LIMIT, 32'd0);
      repeat (5) push_ack(32'd7, 32'd7);
      wait_drained();

      // overrun counter starting from a full window
      set_reg(REG_MODE, {30'd0, aimd_cw_pkg::MODE_COUNT});
      set_reg(REG_DEC_FACTOR, 32'd0);
      push_ack(32'd10, 32'd15);
      push_ack(32'd10, 32'd15);
      push_ack(32'd10, 32'd10);
      wait_drained();

      // multiply to zero, decrement below zero, then grow from the floor
      set_reg(REG_MODE, {30'd0, aimd_cw_pkg::MODE_THRESH});
      push_ack(32'd3, 32'd3);
      wait_drained();
      set_reg(REG_MODE, {30'd0, aimd_cw_pkg::MODE_DELAY});
      set_reg(REG_DEC_FACTOR, 32'hFFF);
      push_ack(32'd1, 32'd10);
      push_ack(32'd4, 32'd4);
      wait_drained();

      for (int p = 0; p < PHASES; p++) begin
         set_reg(REG_MODE, {30'd0, mode_seq[p % 4]});
         if (p == 0) begin
            set_reg(REG_RTT_LIMIT, 32'hFFFF);
            set_reg(REG_SS_LIMIT, 32'hFF_FFFF);
            set_reg(REG_INC_STEP, 32'd0);
            set_reg(REG_DEC_FACTOR, 32'd200);
         end else begin
            set_reg(REG_RTT_LIMIT, pick_value(32'hFFFF, 32'd20, 32'd200));
            set_reg(REG_SS_LIMIT, pick_value(32'hFF_FFFF, 32'd512, 32'd25600));
            set_reg(REG_INC_STEP, pick_value(32'hFFF, 32'd64, 32'd1024));
            set_reg(REG_DEC_FACTOR, pick_value(32'hFFF, 32'd64, 32'd255));
         end
         repeat (WORDS_PER_PHASE) push_random_word();
         // back up the result side while the sender keeps offering
         if (p == 3 || p == 9) begin
            repeat (20) @(posedge clock);
            hold_ticket <= hold_ticket + 1;
         end
         wait_drained();
      end

      if (err_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
